// ===== hw/rtl/mwtg_pkg.sv =====
`timescale 1ns / 1ps
package mwtg_pkg;

	// Delay line and sine table sizes.
	localparam int LINE_DEPTH   = 512;
	localparam int LINE_AW      = $clog2(LINE_DEPTH);
	localparam int SINE_ENTRIES = 256;
	localparam int SINE_BITS    = $clog2(SINE_ENTRIES);

	// Divider and multiplier operand widths.
	localparam int DIV_W  = (SINE_BITS + 10 > 23) ? SINE_BITS + 10 : 23;
	localparam int MUL_AW = 30;
	localparam int MUL_BW = 16;

	// Register map.
	localparam logic REG_NOISE_SEED   = 1'b0;
	localparam logic REG_ATTACK_LEVEL = 1'b1;

	// Reset values.
	localparam logic [15:0] SEED_RESET   = 16'd44257;
	localparam logic [15:0] ATTACK_RESET = 16'd16384;
	localparam logic [7:0]  PERIOD_RESET = 8'd109;
	localparam logic [7:0]  STEP_RESET   = 8'd66;
	localparam logic [15:0] NOISE_TAPS   = 16'hB400;

	// Scale factors.
	localparam logic [14:0] FULL_SCALE   = 15'd32000;
	localparam logic [14:0] SQUARE_SCALE = 15'd22624;

	// Key codes.
	localparam logic [7:0] KEY_WAVE_FIRST = 8'h31;
	localparam logic [7:0] KEY_WAVE_LAST  = 8'h34;
	localparam int NOTES = 11;
	typedef logic [7:0] byte_tab_t [NOTES];
	localparam byte_tab_t NOTE_KEYS    = '{8'h3C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62,
		8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F};
	localparam byte_tab_t NOTE_PERIODS = '{8'd183, 8'd163, 8'd145, 8'd137, 8'd122,
		8'd109, 8'd97, 8'd91, 8'd81, 8'd72, 8'd68};
	localparam byte_tab_t NOTE_STEPS   = '{8'd110, 8'd98, 8'd87, 8'd83, 8'd74, 8'd66,
		8'd58, 8'd55, 8'd49, 8'd44, 8'd41};

	typedef enum logic [1:0] {
		WAVE_SINE   = 2'd0,
		WAVE_SQUARE = 2'd1,
		WAVE_SAW    = 2'd2,
		WAVE_STRING = 2'd3
	} wave_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_DIV,
		ST_MUL,
		ST_RDX,
		ST_RDY,
		ST_WR,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] period;
		logic [7:0] step;
	} note_t;

	// Look up a note key.
	function automatic note_t note_lookup(input logic [7:0] code);
		note_t n;
		n = '0;
		for (int k = 0; k < NOTES; k++) begin
			if (code == NOTE_KEYS[k]) begin
				n.hit    = 1'b1;
				n.period = NOTE_PERIODS[k];
				n.step   = NOTE_STEPS[k];
			end
		end
		return n;
	endfunction

	// Quarter-wave sine table in Q15, built at elaboration from an odd polynomial.
	typedef logic [15:0] sine_tab_t [SINE_ENTRIES + 1];

	function automatic sine_tab_t build_sine();
		sine_tab_t   tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] r;
		for (int k = 0; k <= SINE_ENTRIES; k++) begin
			x  = (64'(k) << 30) / SINE_ENTRIES;
			x2 = (x * x) >> 30;
			t  = 64'd172272;
			t  = 64'd5026995 - ((t * x2) >> 30);
			t  = 64'd85569306 - ((t * x2) >> 30);
			t  = 64'd693598669 - ((t * x2) >> 30);
			t  = 64'd1686629713 - ((t * x2) >> 30);
			r  = (t * x) >> 30;
			r  = (r + 64'd16384) >> 15;
			if (r > 64'd32768) begin
				r = 64'd32768;
			end
			tab[k] = r[15:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// ===== hw/rtl/mwtg_div.sv =====
`timescale 1ns / 1ps
module mwtg_div
	import mwtg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [7:0]       divisor,
	output logic [DIV_W-1:0] quotient,
	output logic             done
);

	localparam int CNT_W = $clog2(DIV_W);

	logic [7:0]       rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [8:0]       trial;
	logic             ge;

	// One quotient bit per cycle, most significant first.
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? 8'(trial - {1'b0, divisor}) : trial[7:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== hw/rtl/mwtg_mul.sv =====
`timescale 1ns / 1ps
module mwtg_mul
	import mwtg_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [MUL_AW-1:0]         a,
	input  logic [MUL_BW-1:0]         b,
	output logic [MUL_AW+MUL_BW-1:0]  prod,
	output logic                      done
);

	localparam int CNT_W = $clog2(MUL_BW);

	logic [MUL_AW-1:0]         a_q;
	logic [MUL_AW+MUL_BW-1:0]  p_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [MUL_AW:0]           sum;

	// Shift-add over the multiplier bits, least significant first.
	assign sum = {1'b0, p_q[MUL_AW+MUL_BW-1:MUL_BW]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MUL_BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{MUL_AW{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[MUL_BW-1:1]};
		end
	end

	assign prod = p_q;
	assign done = done_q;

endmodule

// ===== hw/rtl/multi_waveform_tone_generator.sv =====
`timescale 1ns / 1ps
// Key words are taken while idle; a string-mode note key also fills the delay line with noise.
// Tick words: square uses the serial multiplier, saw and sine the serial divider then the
// serial multiplier, string two reads and one write of the dual-port delay line.
// One word is in work at a time; a finished word waits in the output register meanwhile.
// After reset the delay line is cleared, all LINE_DEPTH entries, while s_tready stays low.
module multi_waveform_tone_generator
	import mwtg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] key_code
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] sample
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t state_q, state_d;

	logic [15:0] seed_q, attack_q, noise_q, amp_q;
	logic [7:0]  period_q, step_q, index_q;
	wave_t       mode_q;
	logic [LINE_AW-1:0] cnt_q;

	logic [15:0] res_q, x_q, rdata_q;
	logic        neg_q;
	logic        m_valid_q, m_last_q;
	logic [15:0] m_data_q;

	logic [15:0] line_mem [LINE_DEPTH];
	logic [LINE_AW-1:0] raddr, waddr;
	logic [15:0] wdata;
	logic        we;

	logic        accept, cfg_we, out_free, cnt_last;
	note_t       note;
	logic [15:0] noise_next;
	logic [7:0]  len, idx;
	logic [8:0]  idx_inc;
	logic        pass_end;

	logic             div_start, div_done;
	logic [DIV_W-1:0] div_dividend, div_quo;
	logic             mul_start, mul_done;
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_AW+MUL_BW-1:0] mul_prod;

	logic [SINE_BITS+1:0] phase;
	logic [SINE_BITS:0]   tab_idx;
	logic [15:0]          tab_q;
	logic [16:0]          mag;
	logic [15:0]          sat;
	logic signed [16:0]   pair_sum;
	logic signed [29:0]   pair_prod;
	logic signed [29:0]   pair_adj;

	assign accept   = s_tvalid && s_tready;
	assign cfg_we   = psel && penable && pwrite && pready;
	assign out_free = !m_valid_q || m_tready;
	assign cnt_last = (cnt_q == LINE_AW'(LINE_DEPTH - 1));
	assign note     = note_lookup(s_tdata);
	assign noise_next = noise_q[0] ? ((noise_q >> 1) ^ NOISE_TAPS) : (noise_q >> 1);

	// Pass length and current index, wrapped when past the end.
	assign len     = (mode_q == WAVE_SQUARE) ? {period_q[7:1], 1'b0} : period_q;
	assign idx     = (index_q >= len) ? 8'd0 : index_q;
	assign idx_inc = {1'b0, idx} + 9'd1;
	assign pass_end = (idx_inc >= {1'b0, len});

	// Configuration registers.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ATTACK_LEVEL) ? {16'd0, attack_q} : {16'd0, seed_q};

	// Serial arithmetic units.
	assign div_dividend = (mode_q == WAVE_SINE) ?
		(DIV_W'(idx) << (SINE_BITS + 2)) : (DIV_W'(idx) * DIV_W'(FULL_SCALE));

	mwtg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (period_q),
		.quotient (div_quo),
		.done     (div_done)
	);

	// Sine table read, mirrored in odd quadrants.
	assign phase   = div_quo[SINE_BITS+1:0];
	assign tab_idx = phase[SINE_BITS] ?
		(SINE_BITS+1)'(SINE_ENTRIES - int'(phase[SINE_BITS-1:0])) :
		{1'b0, phase[SINE_BITS-1:0]};
	assign tab_q   = SINE_TAB[tab_idx];

	always_comb begin
		unique case (mode_q)
			WAVE_SINE:   mul_a = MUL_AW'(tab_q) * MUL_AW'(FULL_SCALE);
			WAVE_SQUARE: mul_a = MUL_AW'(SQUARE_SCALE);
			default:     mul_a = MUL_AW'(div_quo);
		endcase
	end

	mwtg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (amp_q),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	// Magnitude scaling and saturation.
	assign mag = (mode_q == WAVE_SINE) ? 17'(mul_prod >> 30) : 17'(mul_prod >> 15);
	always_comb begin
		if (neg_q) begin
			sat = (mag > 17'd32768) ? 16'h8000 : 16'(17'd0 - mag);
		end else begin
			sat = (mag > 17'd32767) ? 16'h7FFF : mag[15:0];
		end
	end

	// String filter: trunc(4095 * (x + y) / 8192).
	assign pair_sum  = 17'($signed(x_q)) + 17'($signed(rdata_q));
	assign pair_prod = (30'(pair_sum) <<< 12) - 30'(pair_sum);
	assign pair_adj  = pair_prod + (pair_prod[29] ? 30'sd8191 : 30'sd0);

	// Delay line port control.
	always_comb begin
		raddr = LINE_AW'(idx);
		waddr = LINE_AW'(idx);
		wdata = 16'(pair_adj >>> 13);
		we    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				waddr = cnt_q;
				wdata = '0;
				we    = 1'b1;
			end
			ST_FILL: begin
				waddr = cnt_q;
				wdata = noise_next;
				we    = 1'b1;
			end
			ST_RDX: begin
				raddr = (idx == 8'd0) ? LINE_AW'(period_q - 8'd1) : LINE_AW'(idx - 8'd1);
			end
			ST_WR: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			line_mem[waddr] <= wdata;
		end
		rdata_q <= line_mem[raddr];
	end

	// Next state and unit starts.
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		mul_start = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (cnt_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (!s_tuser) begin
						if (note.hit && mode_q == WAVE_STRING && !(s_tdata >= KEY_WAVE_FIRST
							&& s_tdata <= KEY_WAVE_LAST)) begin
							state_d = ST_FILL;
						end
					end else begin
						unique case (mode_q)
							WAVE_SQUARE: begin
								mul_start = 1'b1;
								state_d   = ST_MUL;
							end
							WAVE_STRING: state_d = ST_RDX;
							default: begin
								div_start = 1'b1;
								state_d   = ST_DIV;
							end
						endcase
					end
				end
			end
			ST_FILL: begin
				if (cnt_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					mul_start = 1'b1;
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					state_d = ST_OUT;
				end
			end
			ST_RDX:  state_d = ST_RDY;
			ST_RDY:  state_d = ST_WR;
			ST_WR:   state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control and voice state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= SEED_RESET;
			attack_q  <= ATTACK_RESET;
			noise_q   <= SEED_RESET;
			mode_q    <= WAVE_SINE;
			period_q  <= PERIOD_RESET;
			amp_q     <= '0;
			step_q    <= STEP_RESET;
			index_q   <= '0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (paddr[2] == REG_NOISE_SEED) begin
					seed_q  <= pwdata[15:0];
					noise_q <= pwdata[15:0];
				end else begin
					attack_q <= pwdata[15:0];
				end
			end
			// The output word stays valid until taken; a new one loads when free.
			m_valid_q <= (state_q == ST_OUT && out_free) || (m_valid_q && !m_tready);
			if (state_q == ST_CLEAR || state_q == ST_FILL) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end
			if (state_q == ST_FILL) begin
				noise_q <= noise_next;
			end
			if (accept && !s_tuser) begin
				index_q <= '0;
				if (s_tdata >= KEY_WAVE_FIRST && s_tdata <= KEY_WAVE_LAST) begin
					mode_q <= wave_t'(2'(s_tdata - KEY_WAVE_FIRST));
				end else if (note.hit) begin
					period_q <= note.period;
					amp_q    <= attack_q;
					step_q   <= note.step;
				end
			end
			// Emit the word and advance the pass.
			if (state_q == ST_OUT && out_free) begin
				if (pass_end) begin
					index_q <= '0;
					amp_q   <= (amp_q > 16'(step_q)) ? amp_q - 16'(step_q) : '0;
				end else begin
					index_q <= idx_inc[7:0];
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			neg_q <= (idx >= {1'b0, period_q[7:1]});
		end
		if (state_q == ST_DIV && div_done) begin
			neg_q <= phase[SINE_BITS+1];
		end
		if (state_q == ST_MUL && mul_done) begin
			res_q <= (mode_q == WAVE_SAW) ? ((mag > 17'd32767) ? 16'h7FFF : mag[15:0]) : sat;
		end
		if (state_q == ST_RDY) begin
			x_q <= rdata_q;
		end
		// The current entry arrives last; it is the sample before filtering.
		if (state_q == ST_WR) begin
			res_q <= rdata_q;
		end
		if (state_q == ST_OUT && out_free) begin
			m_data_q <= res_q;
			m_last_q <= pass_end;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

endmodule
